[rtl/wcp_pkg.sv]
`default_nettype none

package wcp_pkg;

  // Window geometry
  localparam int unsigned MaxDistance = 6;
  localparam int unsigned WinDepth    = 2 * MaxDistance + 1;
  localparam int unsigned IdxW        = $clog2(WinDepth);
  localparam int unsigned FillW       = $clog2(WinDepth + 1);

  // Field widths
  localparam int unsigned TermW  = 32;
  localparam int unsigned DateW  = 16;
  localparam int unsigned DistW  = 3;
  localparam int unsigned EntryW = TermW + DateW;

  localparam logic [DistW-1:0] DistReset = 3'd5;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic            load_token;
    logic            load_end;
    logic            issue;
    logic [IdxW-1:0] centre_idx;
    logic [IdxW-1:0] partner_idx;
    logic            last;
  } wcp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [FillW-1:0] fill;
    logic [DistW-1:0] span;
    logic             out_free;
  } wcp_stat_t;

endpackage

`default_nettype wire

[rtl/wcp_if.sv]
`default_nettype none

// Token request channel
interface wcp_in_if;
  import wcp_pkg::*;

  logic             valid;
  logic             ready;
  logic [TermW-1:0] term_id;
  logic [DateW-1:0] token_date;
  logic             sentence_end;

  modport source (output valid, output term_id, output token_date, output sentence_end,
                  input ready);
  modport sink   (input valid, input term_id, input token_date, input sentence_end,
                  output ready);
endinterface

// Pair request channel
interface wcp_out_if;
  import wcp_pkg::*;

  logic             valid;
  logic             ready;
  logic [TermW-1:0] centre_term;
  logic [DateW-1:0] centre_date;
  logic [TermW-1:0] partner_term;
  logic [DateW-1:0] partner_date;
  logic             last_of_run;

  modport source (output valid, output centre_term, output centre_date,
                  output partner_term, output partner_date, output last_of_run,
                  input ready);
  modport sink   (input valid, input centre_term, input centre_date,
                  input partner_term, input partner_date, input last_of_run,
                  output ready);
endinterface

`default_nettype wire

[rtl/wcp_ram.sv]
`default_nettype none

module wcp_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 13,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_a_i,
  input  wire logic [AddrW-1:0] raddr_b_i,
  output logic      [Width-1:0] rdata_a_o,
  output logic      [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Two registered read ports, held while no read is enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

`default_nettype wire

[rtl/wcp_ctrl.sv]
`default_nettype none

module wcp_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_end_i,
  output logic                    in_ready_o,
  input  wire wcp_pkg::wcp_stat_t stat_i,
  output wcp_pkg::wcp_cmd_t       cmd_o
);
  import wcp_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StFwd  = 2'd1;
  localparam logic [1:0] StBwd  = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [IdxW-1:0]  c_q, c_d;
  logic [IdxW-1:0]  j_q, j_d;
  logic [FillW-1:0] lim_q, lim_d;
  logic             multi_q, multi_d;

  logic [FillW-1:0] pend;
  logic [FillW-1:0] fill_new;
  logic [IdxW-1:0]  j_dec;
  logic             centre_done;

  // First phase of a centre: preceding partners if any lie in the sentence
  function automatic logic [1:0] first_state(logic [IdxW-1:0] c, logic [FillW-1:0] lim);
    logic [FillW-1:0] newest;
    newest = lim - 1'b1;
    if (newest > FillW'(c)) begin
      return StFwd;
    end else if (c != '0) begin
      return StBwd;
    end
    return StIdle;
  endfunction

  // First partner of a centre: farthest preceding one, else the nearest following one
  function automatic logic [IdxW-1:0] first_partner(logic [IdxW-1:0] c, logic [FillW-1:0] lim,
                                                    logic [DistW-1:0] d);
    logic [FillW-1:0] newest;
    logic [FillW-1:0] reach;
    newest = lim - 1'b1;
    reach  = FillW'(c) + FillW'(d);
    if (newest > FillW'(c)) begin
      return IdxW'((reach < newest) ? reach : newest);
    end
    return c - 1'b1;
  endfunction

  assign in_ready_o = (state_q == StIdle);
  assign j_dec      = j_q - 1'b1;
  assign fill_new   = (stat_i.fill == FillW'(WinDepth)) ? stat_i.fill : stat_i.fill + 1'b1;
  assign pend       = (stat_i.fill < FillW'(stat_i.span)) ? stat_i.fill : FillW'(stat_i.span);

  // Sequence centres and partners
  always_comb begin
    state_d     = state_q;
    c_d         = c_q;
    j_d         = j_q;
    lim_d       = lim_q;
    multi_d     = multi_q;
    centre_done = 1'b0;

    cmd_o             = '0;
    cmd_o.centre_idx  = c_q;
    cmd_o.partner_idx = j_q;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          if (in_end_i) begin
            // Flush pending centres, from the oldest pending one to the newest
            cmd_o.load_end = 1'b1;
            lim_d          = stat_i.fill;
            multi_d        = 1'b1;
            if (pend != '0) begin
              c_d     = IdxW'(pend - 1'b1);
              state_d = first_state(c_d, stat_i.fill);
              j_d     = first_partner(c_d, stat_i.fill, stat_i.span);
            end
          end else begin
            // Shift in the token; the centre at distance d is now complete
            cmd_o.load_token = 1'b1;
            lim_d            = fill_new;
            multi_d          = 1'b0;
            if (fill_new > FillW'(stat_i.span)) begin
              c_d     = IdxW'(stat_i.span);
              state_d = first_state(c_d, fill_new);
              j_d     = first_partner(c_d, fill_new, stat_i.span);
            end
          end
        end
      end
      StFwd: begin
        if (stat_i.out_free) begin
          cmd_o.issue = 1'b1;
          if (j_dec > c_q) begin
            j_d = j_dec;
          end else if (c_q != '0) begin
            state_d = StBwd;
            j_d     = c_q - 1'b1;
          end else begin
            centre_done = 1'b1;
          end
        end
      end
      StBwd: begin
        if (stat_i.out_free) begin
          cmd_o.issue = 1'b1;
          if (j_q != '0) begin
            j_d = j_dec;
          end else begin
            centre_done = 1'b1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    // Advance to the next newer centre, or finish the request
    if (centre_done) begin
      if (multi_q && (c_q != '0)) begin
        c_d     = c_q - 1'b1;
        state_d = first_state(c_d, lim_q);
        j_d     = first_partner(c_d, lim_q, stat_i.span);
      end else begin
        state_d = StIdle;
      end
    end

    cmd_o.last = cmd_o.issue && (state_d == StIdle);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      c_q     <= '0;
      j_q     <= '0;
      lim_q   <= '0;
      multi_q <= 1'b0;
    end else begin
      state_q <= state_d;
      c_q     <= c_d;
      j_q     <= j_d;
      lim_q   <= lim_d;
      multi_q <= multi_d;
    end
  end

endmodule

`default_nettype wire

[rtl/wcp_datapath.sv]
`default_nettype none

module wcp_datapath (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [wcp_pkg::DistW-1:0] cfg_wdata_i,
  input  wire logic [wcp_pkg::TermW-1:0] term_id_i,
  input  wire logic [wcp_pkg::DateW-1:0] token_date_i,
  input  wire wcp_pkg::wcp_cmd_t         cmd_i,
  input  wire logic                      out_ready_i,
  output wcp_pkg::wcp_stat_t             stat_o,
  output logic                           out_valid_o,
  output logic      [wcp_pkg::TermW-1:0] centre_term_o,
  output logic      [wcp_pkg::DateW-1:0] centre_date_o,
  output logic      [wcp_pkg::TermW-1:0] partner_term_o,
  output logic      [wcp_pkg::DateW-1:0] partner_date_o,
  output logic                           last_of_run_o
);
  import wcp_pkg::*;

  logic [DistW-1:0]  dist_q, dist_d;
  logic [DistW-1:0]  dist_eff;
  logic [FillW-1:0]  fill_q, fill_d;
  logic [IdxW-1:0]   head_q, head_d;
  logic              out_valid_q, out_valid_d;
  logic              last_q;
  logic [IdxW-1:0]   raddr_c;
  logic [IdxW-1:0]   raddr_p;
  logic [EntryW-1:0] rdata_c;
  logic [EntryW-1:0] rdata_p;

  // Map a window position (0 = newest) to its slot in the ring
  function automatic logic [IdxW-1:0] to_slot(logic [IdxW-1:0] head, logic [IdxW-1:0] pos);
    logic [IdxW:0] wrapped;
    wrapped = {1'b0, head} + (IdxW + 1)'(WinDepth) - {1'b0, pos};
    if (head >= pos) begin
      return head - pos;
    end
    return wrapped[IdxW-1:0];
  endfunction

  // Clamp the configured distance into its legal range
  always_comb begin
    dist_eff = dist_q;
    if (dist_q == '0) begin
      dist_eff = DistW'(1);
    end else if (dist_q > DistW'(MaxDistance)) begin
      dist_eff = DistW'(MaxDistance);
    end
  end

  // Window bookkeeping and output handshake
  always_comb begin
    dist_d = cfg_we_i ? cfg_wdata_i : dist_q;

    head_d = head_q;
    fill_d = fill_q;
    if (cmd_i.load_token) begin
      head_d = (head_q == IdxW'(WinDepth - 1)) ? '0 : head_q + 1'b1;
      if (fill_q != FillW'(WinDepth)) begin
        fill_d = fill_q + 1'b1;
      end
    end else if (cmd_i.load_end) begin
      fill_d = '0;
    end

    out_valid_d = cmd_i.issue | (out_valid_q & ~out_ready_i);
  end

  assign raddr_c = to_slot(head_q, cmd_i.centre_idx);
  assign raddr_p = to_slot(head_q, cmd_i.partner_idx);

  wcp_ram #(
    .Width(EntryW),
    .Depth(WinDepth)
  ) u_window (
    .clk_i    (clk_i),
    .we_i     (cmd_i.load_token),
    .waddr_i  (head_d),
    .wdata_i  ({term_id_i, token_date_i}),
    .re_i     (cmd_i.issue),
    .raddr_a_i(raddr_c),
    .raddr_b_i(raddr_p),
    .rdata_a_o(rdata_c),
    .rdata_b_o(rdata_p)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q      <= DistReset;
      fill_q      <= '0;
      head_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      dist_q      <= dist_d;
      fill_q      <= fill_d;
      head_q      <= head_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the run flag next to the read data
  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      last_q <= cmd_i.last;
    end
  end

  assign stat_o.fill     = fill_q;
  assign stat_o.span     = dist_eff;
  assign stat_o.out_free = ~out_valid_q | out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign centre_term_o  = rdata_c[EntryW-1:DateW];
  assign centre_date_o  = rdata_c[DateW-1:0];
  assign partner_term_o = rdata_p[EntryW-1:DateW];
  assign partner_date_o = rdata_p[DateW-1:0];
  assign last_of_run_o  = last_q;

endmodule

`default_nettype wire

[rtl/window_cooccurrence_pairs.sv]
// Sliding-window co-occurrence pair generator.
// in_i carries tokens (term id, date) or a sentence end; out_o carries one
// pair request per beat (centre token, partner token, last-of-run flag).
// A token fills the window; once window_distance later tokens are in, the
// centre at that distance sends its preceding partners oldest first, then
// its following partners nearest first. A sentence end flushes the pending
// centres and empties the window; end of input is sent as a sentence end.
// cfg_we_i/cfg_wdata_i write window_distance; the user must do so only
// while the block is idle, as the block itself does not enforce it. Pairs
// are registered at the dual-read window RAM ports before they are shown.
// Throughput: one pair per cycle while the receiver keeps up.
// A new request is taken while the last pair still waits in the output
// register. When the receiver stalls, the pair is held and issue pauses.
// Reset sets window_distance to 5, empties the window and drops any pair in
// flight; window storage itself is not cleared.
`default_nettype none

module window_cooccurrence_pairs (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [wcp_pkg::DistW-1:0] cfg_wdata_i,
  wcp_in_if.sink                         in_i,
  wcp_out_if.source                      out_o
);
  import wcp_pkg::*;

  wcp_cmd_t  cmd;
  wcp_stat_t stat;
  logic      in_ready;

  assign in_i.ready = in_ready;

  wcp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_i.valid),
    .in_end_i  (in_i.sentence_end),
    .in_ready_o(in_ready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  wcp_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .term_id_i     (in_i.term_id),
    .token_date_i  (in_i.token_date),
    .cmd_i         (cmd),
    .out_ready_i   (out_o.ready),
    .stat_o        (stat),
    .out_valid_o   (out_o.valid),
    .centre_term_o (out_o.centre_term),
    .centre_date_o (out_o.centre_date),
    .partner_term_o(out_o.partner_term),
    .partner_date_o(out_o.partner_date),
    .last_of_run_o (out_o.last_of_run)
  );

`ifndef SYNTH
  // Never overwrite a pair that is still waiting
  a_issue_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.issue |-> (!out_o.valid || out_o.ready))
    else $error("pair issued over a pending pair");

  // Every issued pair shows up at the output
  a_issue_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.issue |=> out_o.valid)
    else $error("issued pair not presented");

  // No new request while pairs are still being issued
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |-> !cmd.issue)
    else $error("request accepted during pair issue");

  // The window count stays within the window
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.fill <= FillW'(WinDepth))
    else $error("window count out of range");
`endif

endmodule

`default_nettype wire
